### hdl/mesh_vertex_dedup_indexer_defines.svh
// Assertion macros used by the dedup indexer back end.
`ifndef MESH_VERTEX_DEDUP_INDEXER_DEFINES_SVH
`define MESH_VERTEX_DEDUP_INDEXER_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define MVDI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dedup indexer check failed");

// Next-cycle implication.
`define MVDI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dedup indexer check failed");

`endif

### hdl/mvdi_pkg.sv
// Shared types and constants of the mesh vertex dedup indexer.
package mvdi_pkg;

	localparam int ATTR_DEPTH_DEF  = 4096;
	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int VI_W   = 12;
	localparam int COMP_W = 32;

	typedef enum logic [2:0] {
		KIND_POS    = 3'd0,
		KIND_NORM   = 3'd1,
		KIND_TEX    = 3'd2,
		KIND_CORNER = 3'd3,
		KIND_GROUP  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		JOB_GROUP = 2'd0,
		JOB_ERR   = 2'd1,
		JOB_VERT  = 2'd2
	} job_kind_t;

	typedef struct packed {
		logic [COMP_W-1:0] pos_x;
		logic [COMP_W-1:0] pos_y;
		logic [COMP_W-1:0] pos_z;
		logic [COMP_W-1:0] norm_x;
		logic [COMP_W-1:0] norm_y;
		logic [COMP_W-1:0] norm_z;
		logic [COMP_W-1:0] tex_u;
		logic [COMP_W-1:0] tex_v;
	} vertex_t;

	typedef struct packed {
		job_kind_t kind;
		logic [1:0] corner;
		vertex_t    vtx;
	} job_t;

endpackage

### hdl/mvdi_channels.sv
// Input and result channel interfaces of the mesh vertex dedup indexer.
interface mvdi_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] x_bits;
	logic [31:0] y_bits;
	logic [31:0] z_bits;
	logic [12:0] pos_index;
	logic [12:0] norm_index;
	logic [12:0] tex_index;
	logic [1:0]  corner_number;

	modport source (output valid, kind, x_bits, y_bits, z_bits, pos_index, norm_index,
		tex_index, corner_number, input ready);
	modport sink (input valid, kind, x_bits, y_bits, z_bits, pos_index, norm_index,
		tex_index, corner_number, output ready);
endinterface

interface mvdi_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] vtx_index;
	logic        is_new;
	logic [31:0] out_pos_x;
	logic [31:0] out_pos_y;
	logic [31:0] out_pos_z;
	logic [31:0] out_norm_x;
	logic [31:0] out_norm_y;
	logic [31:0] out_norm_z;
	logic [31:0] out_tex_u;
	logic [31:0] out_tex_v;
	logic        last_of_run;
	logic [1:0]  status;

	modport source (output valid, vtx_index, is_new, out_pos_x, out_pos_y, out_pos_z,
		out_norm_x, out_norm_y, out_norm_z, out_tex_u, out_tex_v, last_of_run, status,
		input ready);
	modport sink (input valid, vtx_index, is_new, out_pos_x, out_pos_y, out_pos_z,
		out_norm_x, out_norm_y, out_norm_z, out_tex_u, out_tex_v, last_of_run, status,
		output ready);
endinterface

### hdl/mvdi_front.sv
// Front end: attribute stores, corner validation and job issue.
module mvdi_front #(
	parameter int ATTR_DEPTH = mvdi_pkg::ATTR_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	mvdi_in_if.sink         items,
	output logic            job_valid,
	input  logic            job_ready,
	output mvdi_pkg::job_t  job
);
	localparam int AW = $clog2(ATTR_DEPTH);
	localparam int CW = $clog2(ATTR_DEPTH + 1);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_PUSH = 2'b10
	} fstate_t;

	fstate_t state_q;
	logic [CW-1:0] pos_cnt_q, norm_cnt_q, tex_cnt_q;
	logic mesh_open_q;
	mvdi_pkg::job_kind_t kind_q;
	logic [1:0] corner_q;

	logic [95:0] pos_mem  [ATTR_DEPTH];
	logic [95:0] norm_mem [ATTR_DEPTH];
	logic [63:0] tex_mem  [ATTR_DEPTH];
	logic [95:0] pos_rd_q, norm_rd_q;
	logic [63:0] tex_rd_q;

	logic acc, pos_wr, norm_wr, tex_wr, corner_ok;
	logic [12:0] pi_m1, ni_m1, ti_m1;

	assign items.ready = (state_q == F_IDLE);
	assign acc = items.valid && items.ready;

	assign pos_wr  = acc && items.kind == mvdi_pkg::KIND_POS
		&& 32'(pos_cnt_q) < 32'(ATTR_DEPTH);
	assign norm_wr = acc && items.kind == mvdi_pkg::KIND_NORM
		&& 32'(norm_cnt_q) < 32'(ATTR_DEPTH);
	assign tex_wr  = acc && items.kind == mvdi_pkg::KIND_TEX
		&& 32'(tex_cnt_q) < 32'(ATTR_DEPTH);

	assign pi_m1 = items.pos_index - 13'd1;
	assign ni_m1 = items.norm_index - 13'd1;
	assign ti_m1 = items.tex_index - 13'd1;

	// Check the group is open and every index lies within its store
	assign corner_ok = mesh_open_q
		&& items.pos_index != 13'd0 && 32'(items.pos_index) <= 32'(pos_cnt_q)
		&& items.norm_index != 13'd0 && 32'(items.norm_index) <= 32'(norm_cnt_q)
		&& items.tex_index != 13'd0 && 32'(items.tex_index) <= 32'(tex_cnt_q);

	// Write attribute stores and read the corner's attributes
	always_ff @(posedge clk) begin
		if (pos_wr) pos_mem[AW'(pos_cnt_q)] <= {items.x_bits, items.y_bits, items.z_bits};
		if (norm_wr) norm_mem[AW'(norm_cnt_q)] <= {items.x_bits, items.y_bits, items.z_bits};
		if (tex_wr) tex_mem[AW'(tex_cnt_q)] <= {items.x_bits, items.y_bits};
		if (acc) begin
			pos_rd_q  <= pos_mem[AW'(pi_m1)];
			norm_rd_q <= norm_mem[AW'(ni_m1)];
			tex_rd_q  <= tex_mem[AW'(ti_m1)];
		end
	end

	// Count attributes, track the open group and sequence job issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			pos_cnt_q   <= '0;
			norm_cnt_q  <= '0;
			tex_cnt_q   <= '0;
			mesh_open_q <= 1'b0;
			kind_q      <= mvdi_pkg::JOB_GROUP;
			corner_q    <= 2'd0;
		end else begin
			if (pos_wr) pos_cnt_q <= pos_cnt_q + 1'b1;
			if (norm_wr) norm_cnt_q <= norm_cnt_q + 1'b1;
			if (tex_wr) tex_cnt_q <= tex_cnt_q + 1'b1;
			case (state_q)
				F_IDLE: begin
					if (acc && items.kind == mvdi_pkg::KIND_GROUP) begin
						mesh_open_q <= 1'b1;
						kind_q      <= mvdi_pkg::JOB_GROUP;
						state_q     <= F_PUSH;
					end else if (acc && items.kind == mvdi_pkg::KIND_CORNER) begin
						kind_q   <= corner_ok ? mvdi_pkg::JOB_VERT : mvdi_pkg::JOB_ERR;
						corner_q <= items.corner_number;
						state_q  <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (job_ready) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign job_valid = (state_q == F_PUSH);
	assign job = {kind_q, corner_q, pos_rd_q, norm_rd_q, tex_rd_q};
endmodule

### hdl/mvdi_fifo.sv
// Two-entry job queue between front and back ends.
module mvdi_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  mvdi_pkg::job_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output mvdi_pkg::job_t  pop_data
);
	mvdi_pkg::job_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign do_push = push_valid && push_ready;
	assign do_pop  = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule

### hdl/mvdi_back.sv
// Back end: dedup table scan, vertex append and result sequencing.
`include "mesh_vertex_dedup_indexer_defines.svh"
module mvdi_back #(
	parameter int TABLE_DEPTH = mvdi_pkg::TABLE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  mvdi_pkg::job_t  job,
	mvdi_out_if.source      results
);
	localparam int TW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int VW = mvdi_pkg::VI_W;

	typedef enum logic [3:0] {
		B_IDLE   = 4'b0001,
		B_SCAN   = 4'b0010,
		B_DECIDE = 4'b0100,
		B_OUT    = 4'b1000
	} bstate_t;

	bstate_t state_q;
	mvdi_pkg::job_t job_q;
	logic [CW-1:0] vc_q, rd_ptr_q;
	logic cmp_vld_s1;
	logic [TW-1:0] cmp_idx_s1;
	mvdi_pkg::vertex_t key_s1;
	mvdi_pkg::vertex_t key_mem [TABLE_DEPTH];
	logic found_q, fin_new_q;
	logic [VW-1:0] fin_idx_q, first_q, third_q;
	mvdi_pkg::status_t fin_status_q;
	logic [1:0] step_q;

	logic issue, match, key_wr, out_xfer, table_full;

	assign job_ready  = (state_q == B_IDLE);
	assign issue      = (state_q == B_SCAN) && (rd_ptr_q < vc_q);
	assign match      = cmp_vld_s1 && (key_s1 == job_q.vtx);
	assign table_full = (vc_q == CW'(TABLE_DEPTH));
	assign key_wr     = (state_q == B_DECIDE) && !found_q && !table_full;
	assign out_xfer   = results.valid && results.ready;

	// Key table: one read per scan cycle, append on a new vertex
	always_ff @(posedge clk) begin
		if (key_wr) key_mem[TW'(vc_q)] <= job_q.vtx;
		if (issue) key_s1 <= key_mem[TW'(rd_ptr_q)];
	end

	// Sequence scan, decision and result transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			job_q        <= '0;
			vc_q         <= '0;
			rd_ptr_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			found_q      <= 1'b0;
			fin_new_q    <= 1'b0;
			fin_idx_q    <= '0;
			fin_status_q <= mvdi_pkg::ST_OK;
			step_q       <= 2'd0;
			first_q      <= '0;
			third_q      <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					cmp_vld_s1 <= 1'b0;
					rd_ptr_q   <= '0;
					found_q    <= 1'b0;
					if (job_valid) begin
						job_q <= job;
						case (job.kind)
							mvdi_pkg::JOB_GROUP: vc_q <= '0;
							mvdi_pkg::JOB_ERR: begin
								fin_idx_q    <= '0;
								fin_new_q    <= 1'b0;
								fin_status_q <= mvdi_pkg::ST_BAD;
								step_q       <= 2'd2;
								state_q      <= B_OUT;
							end
							mvdi_pkg::JOB_VERT: state_q <= B_SCAN;
							default: state_q <= B_IDLE;
						endcase
					end
				end
				B_SCAN: begin
					cmp_vld_s1 <= issue;
					cmp_idx_s1 <= TW'(rd_ptr_q);
					if (issue) rd_ptr_q <= rd_ptr_q + 1'b1;
					if (match) begin
						found_q   <= 1'b1;
						fin_idx_q <= VW'(cmp_idx_s1);
						state_q   <= B_DECIDE;
					end else if (!issue && !cmp_vld_s1) begin
						state_q <= B_DECIDE;
					end
				end
				B_DECIDE: begin
					state_q <= B_OUT;
					if (found_q) begin
						fin_new_q    <= 1'b0;
						fin_status_q <= mvdi_pkg::ST_OK;
						step_q       <= (job_q.corner == 2'd3) ? 2'd0 : 2'd2;
					end else if (table_full) begin
						fin_idx_q    <= '0;
						fin_new_q    <= 1'b0;
						fin_status_q <= mvdi_pkg::ST_FULL;
						step_q       <= 2'd2;
					end else begin
						fin_idx_q    <= VW'(vc_q);
						fin_new_q    <= 1'b1;
						fin_status_q <= mvdi_pkg::ST_OK;
						vc_q         <= vc_q + 1'b1;
						step_q       <= (job_q.corner == 2'd3) ? 2'd0 : 2'd2;
					end
				end
				B_OUT: begin
					if (out_xfer) begin
						if (step_q != 2'd2) begin
							step_q <= step_q + 2'd1;
						end else begin
							state_q <= B_IDLE;
							if (fin_status_q == mvdi_pkg::ST_OK) begin
								if (job_q.corner == 2'd0) first_q <= fin_idx_q;
								if (job_q.corner == 2'd2) third_q <= fin_idx_q;
							end
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Drive the result from held registers
	logic show_data;
	assign show_data = (step_q == 2'd2) && fin_new_q;
	assign results.valid        = (state_q == B_OUT);
	assign results.vtx_index    = (step_q == 2'd0) ? first_q :
		(step_q == 2'd1) ? third_q : fin_idx_q;
	assign results.is_new      = show_data;
	assign results.out_pos_x   = show_data ? job_q.vtx.pos_x : '0;
	assign results.out_pos_y   = show_data ? job_q.vtx.pos_y : '0;
	assign results.out_pos_z   = show_data ? job_q.vtx.pos_z : '0;
	assign results.out_norm_x  = show_data ? job_q.vtx.norm_x : '0;
	assign results.out_norm_y  = show_data ? job_q.vtx.norm_y : '0;
	assign results.out_norm_z  = show_data ? job_q.vtx.norm_z : '0;
	assign results.out_tex_u   = show_data ? job_q.vtx.tex_u : '0;
	assign results.out_tex_v   = show_data ? job_q.vtx.tex_v : '0;
	assign results.last_of_run = (step_q == 2'd2);
	assign results.status      = (step_q == 2'd2) ? fin_status_q : mvdi_pkg::ST_OK;

	`MVDI_ASSERT_NOW(a_vc_bound, 1'b1, vc_q <= CW'(TABLE_DEPTH))
	`MVDI_ASSERT_NOW(a_new_ok, results.valid && results.is_new,
		fin_status_q == mvdi_pkg::ST_OK)
	`MVDI_ASSERT_NEXT(a_append, key_wr, vc_q == CW'($past(vc_q) + 1'b1))
	`MVDI_ASSERT_NOW(a_reemit_quad, results.valid && step_q != 2'd2, job_q.corner == 2'd3)
endmodule

### hdl/mesh_vertex_dedup_indexer.sv
// Top level of the mesh vertex dedup indexer.
// Usage: items arrive on the items channel (valid/ready), results leave on the
// results channel. Position, normal and texture items append to their stores and
// give no result; a group item opens a new mesh and empties the dedup table.
// A face corner gives one result, or three on corner 3 (corners 0 and 2 re-sent
// first, unless it fails); last_of_run marks the final one. Bad indices or a
// missing group give status 2, a full table status 1.
// Flow: the front end takes one attribute item per cycle while it is idle; a
// corner or group item is held through a store read and then a queue push
// before the next item is taken. The back end scans the key table linearly,
// one entry per cycle through its single read port.
// A two-entry job queue lets the front keep filling stores while the back scans.
// Reset: counts, group state and the queue clear at once; stores need no
// clearing pass and their data is used only below their fill counts.
// Stall: a held result stays on the port; the back end waits, the queue fills,
// and then items.ready stays low once a corner or group item awaits its push.
module mesh_vertex_dedup_indexer #(
	parameter int ATTR_DEPTH  = mvdi_pkg::ATTR_DEPTH_DEF,
	parameter int TABLE_DEPTH = mvdi_pkg::TABLE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mvdi_in_if.sink    items,
	mvdi_out_if.source results
);
	logic fr_valid, fr_ready, bk_valid, bk_ready;
	mvdi_pkg::job_t fr_job, bk_job;

	// Accept and classify items
	mvdi_front #(.ATTR_DEPTH(ATTR_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .items(items),
		.job_valid(fr_valid), .job_ready(fr_ready), .job(fr_job)
	);

	// Decouple front and back
	mvdi_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_valid(fr_valid), .push_ready(fr_ready), .push_data(fr_job),
		.pop_valid(bk_valid), .pop_ready(bk_ready), .pop_data(bk_job)
	);

	// Dedup and emit results
	mvdi_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(bk_valid), .job_ready(bk_ready), .job(bk_job),
		.results(results)
	);
endmodule
